@@ hdl/flv_tag_deframer_core_assert.svh @@
`ifndef FLV_TAG_DEFRAMER_CORE_ASSERT_SVH
`define FLV_TAG_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, checked after reset
`define FLVD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("flvd assertion failed");

// next-cycle implication, checked after reset
`define FLVD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("flvd assertion failed");

`endif

@@ hdl/flvd_pkg.sv @@
package flvd_pkg;

    localparam logic [7:0]  TAG_AUDIO = 8'h08;
    localparam logic [7:0]  TAG_VIDEO = 8'h09;

    localparam logic [1:0]  STATUS_DATA      = 2'd0;
    localparam logic [1:0]  STATUS_BAD_SIG   = 2'd1;
    localparam logic [1:0]  STATUS_BAD_VER   = 2'd2;
    localparam logic [1:0]  STATUS_NO_STREAM = 2'd3;

    localparam logic [2:0]  CODEC_AUDIO_OTHER = 3'd4;
    localparam logic [2:0]  CODEC_H263        = 3'd5;
    localparam logic [2:0]  CODEC_VP6         = 3'd6;
    localparam logic [2:0]  CODEC_VIDEO_OTHER = 3'd7;

    localparam logic [3:0]  VCODEC_H263 = 4'd2;
    localparam logic [3:0]  VCODEC_VP6  = 4'd4;
    localparam logic [3:0]  VCODEC_VP6A = 4'd5;

    localparam int          CHUNK_W           = 17;
    localparam logic [16:0] MAX_CHUNK_RESET   = 17'd8192;
    localparam int          PADDR_W           = 3;
    localparam logic        REG_MAX_CHUNK     = 1'b0;

    localparam logic [15:0] SAMPLE_RATE_BASE  = 16'd44100;
    localparam logic [38:0] PTS_SCALE         = 39'd90;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        is_video;
        logic [2:0]  codec;
        logic        keyframe;
        logic [38:0] pts_90k;
        logic        chunk_last;
        logic        frame_last;
        logic [1:0]  status;
        logic        stream_first;
        logic [15:0] sample_rate;
        logic [4:0]  sample_bits;
        logic [1:0]  channels;
    } flvd_result_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] r;
        unique case (idx)
            2'd0:    r = 8'h46;
            2'd1:    r = 8'h4C;
            default: r = 8'h56;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] sample_rate_of(input logic [1:0] rate_code);
        return SAMPLE_RATE_BASE >> (2'd3 - rate_code);
    endfunction

endpackage

@@ hdl/flvd_parse.sv @@
module flvd_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [7:0]            data_byte,
    input  logic                  restart,
    input  logic [16:0]           max_chunk_bytes,
    output logic                  res_valid,
    output flvd_pkg::flvd_result_t res
);
    import flvd_pkg::*;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_OFFSET  = 3'd1;
    localparam logic [2:0] PH_PREV    = 3'd2;
    localparam logic [2:0] PH_TAG     = 3'd3;
    localparam logic [2:0] PH_CODEC   = 3'd4;
    localparam logic [2:0] PH_EXTRA   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_SKIP    = 3'd7;

    logic [2:0]  phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  kind_reg, kind_next;
    logic [23:0] left_reg, left_next;
    logic [31:0] time_reg, time_next;
    logic [7:0]  codec_reg, codec_next;
    logic [16:0] chunk_reg, chunk_next;
    logic        seen_a_reg, seen_a_next;
    logic        seen_v_reg, seen_v_next;
    logic        err_reg, err_next;
    logic        first_reg, first_next;

    always_comb begin
        logic [2:0]  ph;
        logic [31:0] cnt;
        logic [31:0] sh;
        logic [7:0]  kd;
        logic [23:0] lf;
        logic [31:0] tm;
        logic [7:0]  cb;
        logic [16:0] ck;
        logic        sa, sv, er, fs;
        logic [1:0]  code;
        logic [2:0]  extra;
        logic [16:0] limit;
        logic [16:0] ck_inc;
        logic        video, fl, cl;
        logic [3:0]  hi, lo;

        ph = phase_reg; cnt = count_reg; sh = shift_reg; kd = kind_reg;
        lf = left_reg; tm = time_reg; cb = codec_reg; ck = chunk_reg;
        sa = seen_a_reg; sv = seen_v_reg; er = err_reg; fs = first_reg;
        if (restart) begin
            ph = PH_HEADER; cnt = '0; sh = '0; kd = '0; lf = '0; tm = '0;
            cb = '0; ck = '0; sa = 1'b0; sv = 1'b0; er = 1'b0; fs = 1'b0;
        end

        phase_next = ph; count_next = cnt; shift_next = sh; kind_next = kd;
        left_next = lf; time_next = tm; codec_next = cb; chunk_next = ck;
        seen_a_next = sa; seen_v_next = sv; err_next = er; first_next = fs;
        res_valid = 1'b0;
        res = '0;
        code = STATUS_DATA;
        extra = '0;
        limit = (max_chunk_bytes == '0) ? 17'd1 : max_chunk_bytes;
        ck_inc = ck + 17'd1;
        video = (kd == TAG_VIDEO);
        hi = cb[7:4];
        lo = cb[3:0];
        fl = 1'b0;
        cl = 1'b0;

        if (!er) begin
            unique case (ph)
                PH_HEADER: begin
                    if (cnt < 32'd3) begin
                        if (data_byte != sig_byte(cnt[1:0])) code = STATUS_BAD_SIG;
                    end else if (cnt == 32'd3) begin
                        if (data_byte != 8'h01) code = STATUS_BAD_VER;
                    end else if (cnt == 32'd4) begin
                        if ((data_byte & 8'h05) == 8'h00) code = STATUS_NO_STREAM;
                    end else begin
                        shift_next = {sh[23:0], data_byte};
                    end
                    if (code != STATUS_DATA) begin
                        err_next = 1'b1;
                        res_valid = 1'b1;
                        res.status = code;
                    end else begin
                        count_next = cnt + 32'd1;
                        if (cnt >= 32'd8) begin
                            if (shift_next <= 32'd9) begin
                                phase_next = PH_PREV;
                                count_next = '0;
                            end else begin
                                phase_next = PH_OFFSET;
                                count_next = 32'd9;
                            end
                        end
                    end
                end
                PH_OFFSET: begin
                    count_next = cnt + 32'd1;
                    if (count_next >= sh) begin
                        phase_next = PH_PREV;
                        count_next = '0;
                    end
                end
                PH_PREV: begin
                    count_next = cnt + 32'd1;
                    if (count_next >= 32'd4) begin
                        phase_next = PH_TAG;
                        count_next = '0;
                        shift_next = '0;
                        time_next = '0;
                    end
                end
                PH_TAG: begin
                    if (cnt == 32'd0) begin
                        kind_next = data_byte;
                    end else if (cnt <= 32'd3) begin
                        shift_next = {8'h00, sh[15:0], data_byte};
                    end else if (cnt <= 32'd6) begin
                        time_next = {8'h00, tm[15:0], data_byte};
                    end else if (cnt == 32'd7) begin
                        time_next = tm | {data_byte, 24'h000000};
                    end
                    count_next = cnt + 32'd1;
                    if (cnt >= 32'd10) begin
                        left_next = sh[23:0];
                        first_next = 1'b0;
                        if (left_next == '0) begin
                            phase_next = PH_PREV;
                            count_next = '0;
                        end else if (kd == TAG_AUDIO || kd == TAG_VIDEO) begin
                            phase_next = PH_CODEC;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_CODEC: begin
                    codec_next = data_byte;
                    left_next = lf - 24'd1;
                    if (video) begin
                        if (!sv) begin
                            seen_v_next = 1'b1;
                            first_next = 1'b1;
                        end
                        if (data_byte[3:0] == VCODEC_VP6) extra = 3'd1;
                        else if (data_byte[3:0] == VCODEC_VP6A) extra = 3'd4;
                    end else begin
                        if (!sa) begin
                            seen_a_next = 1'b1;
                            first_next = 1'b1;
                        end
                    end
                    if (24'(extra) > left_next) extra = left_next[2:0];
                    if (extra != '0) begin
                        phase_next = PH_EXTRA;
                        count_next = 32'(extra);
                    end else begin
                        chunk_next = '0;
                        if (left_next != '0) begin
                            phase_next = PH_PAYLOAD;
                        end else begin
                            phase_next = PH_PREV;
                            count_next = '0;
                        end
                    end
                end
                PH_EXTRA: begin
                    left_next = lf - 24'd1;
                    count_next = cnt - 32'd1;
                    if (count_next == '0 || left_next == '0) begin
                        chunk_next = '0;
                        if (left_next != '0) begin
                            phase_next = PH_PAYLOAD;
                        end else begin
                            phase_next = PH_PREV;
                            count_next = '0;
                        end
                    end
                end
                PH_SKIP: begin
                    left_next = lf - 24'd1;
                    if (left_next == '0) begin
                        phase_next = PH_PREV;
                        count_next = '0;
                    end
                end
                PH_PAYLOAD: begin
                    left_next = lf - 24'd1;
                    fl = (left_next == '0);
                    cl = fl || (ck_inc >= limit);
                    chunk_next = cl ? 17'd0 : ck_inc;
                    res_valid = 1'b1;
                    res.payload_byte = data_byte;
                    res.is_video = video;
                    if (video) begin
                        if (lo == VCODEC_H263) res.codec = CODEC_H263;
                        else if (lo == VCODEC_VP6 || lo == VCODEC_VP6A) res.codec = CODEC_VP6;
                        else res.codec = CODEC_VIDEO_OTHER;
                    end else begin
                        res.codec = (hi <= 4'd3) ? hi[2:0] : CODEC_AUDIO_OTHER;
                    end
                    res.keyframe = video && (hi == 4'd1);
                    res.pts_90k = {7'b0, tm} * PTS_SCALE;
                    res.chunk_last = cl;
                    res.frame_last = fl;
                    res.status = STATUS_DATA;
                    res.stream_first = fs;
                    if (!video && fs) begin
                        res.sample_rate = sample_rate_of(cb[3:2]);
                        res.sample_bits = cb[1] ? 5'd16 : 5'd8;
                        res.channels = {1'b0, cb[0]} + 2'd1;
                    end
                    if (fl) begin
                        phase_next = PH_PREV;
                        count_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            count_reg  <= '0;
            shift_reg  <= '0;
            kind_reg   <= '0;
            left_reg   <= '0;
            time_reg   <= '0;
            codec_reg  <= '0;
            chunk_reg  <= '0;
            seen_a_reg <= 1'b0;
            seen_v_reg <= 1'b0;
            err_reg    <= 1'b0;
            first_reg  <= 1'b0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            kind_reg   <= kind_next;
            left_reg   <= left_next;
            time_reg   <= time_next;
            codec_reg  <= codec_next;
            chunk_reg  <= chunk_next;
            seen_a_reg <= seen_a_next;
            seen_v_reg <= seen_v_next;
            err_reg    <= err_next;
            first_reg  <= first_next;
        end
    end

endmodule

@@ hdl/flvd_skid.sv @@
module flvd_skid (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  flvd_pkg::flvd_result_t push_data,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output flvd_pkg::flvd_result_t m_data
);
    import flvd_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    flvd_result_t out_data_reg, out_data_next;
    flvd_result_t skid_data_reg, skid_data_next;
    logic         pop;

    assign pop     = out_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

@@ hdl/flv_tag_deframer_core.sv @@
// Channel   Handshake           Beat contents
// s_        s_valid / s_ready   s_data_byte, s_restart
// m_        m_valid / m_ready   payload byte with stream, codec, time and format fields
// apb       psel / penable      max_chunk_bytes at byte address 0
//
// One input beat per clock while s_ready is high; result beats leave from a register.
// Each beat passes once through the parse logic into a two-entry output buffer.
// Synchronous active-low aresetn clears parse state, max_chunk_bytes returns to 8192.
// With m_ready low the output buffer fills, then s_ready drops until a beat leaves.
`include "flv_tag_deframer_core_assert.svh"

module flv_tag_deframer_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_payload_byte,
    output logic                          m_is_video,
    output logic [2:0]                    m_codec,
    output logic                          m_keyframe,
    output logic [38:0]                   m_pts_90k,
    output logic                          m_chunk_last,
    output logic                          m_frame_last,
    output logic [1:0]                    m_status,
    output logic                          m_stream_first,
    output logic [15:0]                   m_sample_rate,
    output logic [4:0]                    m_sample_bits,
    output logic [1:0]                    m_channels,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [flvd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import flvd_pkg::*;

    logic         fire;
    logic         res_valid;
    flvd_result_t res;
    flvd_result_t m_data;
    logic [16:0]  max_chunk_reg;
    logic         reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[PADDR_W-1] == REG_MAX_CHUNK);
    assign prdata  = reg_hit ? {15'b0, max_chunk_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chunk_reg <= MAX_CHUNK_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            max_chunk_reg <= pwdata[CHUNK_W-1:0];
        end
    end

    assign fire = s_valid && s_ready;

    flvd_parse u_parse (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .fire            (fire),
        .data_byte       (s_data_byte),
        .restart         (s_restart),
        .max_chunk_bytes (max_chunk_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    flvd_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fire && res_valid),
        .push_data (res),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_payload_byte = m_data.payload_byte;
    assign m_is_video     = m_data.is_video;
    assign m_codec        = m_data.codec;
    assign m_keyframe     = m_data.keyframe;
    assign m_pts_90k      = m_data.pts_90k;
    assign m_chunk_last   = m_data.chunk_last;
    assign m_frame_last   = m_data.frame_last;
    assign m_status       = m_data.status;
    assign m_stream_first = m_data.stream_first;
    assign m_sample_rate  = m_data.sample_rate;
    assign m_sample_bits  = m_data.sample_bits;
    assign m_channels     = m_data.channels;

    `FLVD_ASSERT_NOW(a_stall_only_when_full, !s_ready, m_valid)
    `FLVD_ASSERT_NOW(a_frame_ends_chunk, m_valid && m_frame_last, m_chunk_last)
    `FLVD_ASSERT_NOW(a_error_beat_clean, m_valid && m_status != STATUS_DATA, m_payload_byte == 8'h00 && m_pts_90k == 39'd0 && !m_chunk_last && !m_stream_first)
    `FLVD_ASSERT_NOW(a_format_first_audio, m_valid && m_sample_rate != 16'd0, !m_is_video && m_stream_first && m_sample_bits != 5'd0)

endmodule

@@ tb/flv_tag_deframer_core_test.sv @@
module flv_tag_deframer_core_test;
    import flvd_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR,
        PH_OFS,
        PH_PREV,
        PH_TAG,
        PH_CODEC,
        PH_EXTRA,
        PH_PAYLOAD,
        PH_SKIP
    } phase_e;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       known;
        logic       want_beat;
        logic [1:0] status;
    } plan_row_t;

    localparam logic [23:0]        FLV_SIG        = 24'h464C56;
    localparam logic [7:0]         FLV_VERSION    = 8'h01;
    localparam logic [7:0]         STREAM_FLAGS   = 8'h05;
    localparam logic [7:0]         TAG_SCRIPT     = 8'h12;
    localparam logic [PADDR_W-1:0] MAX_CHUNK_ADDR = PADDR_W'(4 * REG_MAX_CHUNK);
    localparam int                 PHASES         = 7;
    localparam int                 BEATS_PER_PHASE = 218;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [7:0]          s_data_byte = 8'h00;
    logic                s_restart = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [7:0]          m_payload_byte;
    logic                m_is_video;
    logic [2:0]          m_codec;
    logic                m_keyframe;
    logic [38:0]         m_pts_90k;
    logic                m_chunk_last;
    logic                m_frame_last;
    logic [1:0]          m_status;
    logic                m_stream_first;
    logic [15:0]         m_sample_rate;
    logic [4:0]          m_sample_bits;
    logic [1:0]          m_channels;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = 32'h0;
    logic [31:0]         prdata;
    logic                pready;

    // directed row tag that travels with the beat
    logic                plan_known = 1'b0;
    logic                plan_want_beat = 1'b0;
    logic [1:0]          plan_status = STATUS_DATA;

    // deframer state as seen by the predictor
    phase_e              ph;
    logic [31:0]         field_cnt;
    logic [31:0]         hdr_shift;
    logic [31:0]         data_ofs;
    logic [7:0]          tag_code;
    logic [23:0]         bytes_to_go;
    logic [31:0]         stamp_ms;
    logic [7:0]          codec_id;
    logic [16:0]         chunk_fill;
    logic [16:0]         chunk_limit;
    logic                have_audio;
    logic                have_video;
    logic                halted;
    logic                first_tag;

    flvd_result_t        pending_beats[$];

    logic                src_steady = 1'b0;
    logic                sink_steady = 1'b0;
    int                  fail_count = 0;
    int                  fed_beats = 0;
    int                  file_count = 0;
    int                  noise_count = 0;
    int                  result_count = 0;
    int                  chunk_end_count = 0;
    int                  frame_end_count = 0;
    int                  error_beat_count = 0;

    plan_row_t directed_rows [25] = '{
        '{8'hFF, 1'b1, 1'b1, 1'b1, STATUS_BAD_SIG},
        '{8'h46, 1'b0, 1'b1, 1'b0, STATUS_DATA},
        '{8'h46, 1'b1, 1'b0, 1'b0, STATUS_DATA},
        '{8'h00, 1'b0, 1'b1, 1'b1, STATUS_BAD_SIG},
        '{8'h46, 1'b1, 1'b0, 1'b0, STATUS_DATA},
        '{8'h4C, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h57, 1'b0, 1'b1, 1'b1, STATUS_BAD_SIG},
        '{8'h46, 1'b1, 1'b0, 1'b0, STATUS_DATA},
        '{8'h4C, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h56, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h00, 1'b0, 1'b1, 1'b1, STATUS_BAD_VER},
        '{8'h46, 1'b1, 1'b0, 1'b0, STATUS_DATA},
        '{8'h4C, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h56, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h01, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'hFA, 1'b0, 1'b1, 1'b1, STATUS_NO_STREAM},
        '{8'h46, 1'b1, 1'b0, 1'b0, STATUS_DATA},
        '{8'h4C, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h56, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h01, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h01, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_DATA},
        '{8'h00, 1'b0, 1'b0, 1'b0, STATUS_DATA}
    };

    logic [31:0] limit_plan [PHASES] = '{
        32'd0, 32'd0, 32'd1, 32'd65536, 32'hFFFF_FFFF, 32'd2, 32'd0
    };

    flv_tag_deframer_core u_top (.*);

    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    function automatic void clear_parse();
        ph          = PH_HDR;
        field_cnt   = 0;
        hdr_shift   = 0;
        data_ofs    = 0;
        tag_code    = 0;
        bytes_to_go = 0;
        stamp_ms    = 0;
        codec_id    = 0;
        chunk_fill  = 0;
        have_audio  = 1'b0;
        have_video  = 1'b0;
        halted      = 1'b0;
        first_tag   = 1'b0;
    endfunction

    function automatic void enter_prev();
        ph        = PH_PREV;
        field_cnt = 0;
    endfunction

    function automatic void enter_payload();
        chunk_fill = 0;
        if (bytes_to_go != 0) begin
            ph = PH_PAYLOAD;
        end else begin
            enter_prev();
        end
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic rs,
                                         output logic emits, output flvd_result_t beat);
        logic [31:0] pos;
        logic [1:0]  code;
        logic [31:0] extra;
        logic [3:0]  hi;
        logic [3:0]  lo;
        logic        video;
        emits = 1'b0;
        beat  = '0;
        if (rs) begin
            clear_parse();
        end
        if (halted) begin
            return;
        end
        case (ph)
            PH_HDR: begin
                pos  = field_cnt;
                code = STATUS_DATA;
                if (pos < 3) begin
                    if (b != FLV_SIG[23 - 8 * pos -: 8]) code = STATUS_BAD_SIG;
                end else if (pos == 3) begin
                    if (b != FLV_VERSION) code = STATUS_BAD_VER;
                end else if (pos == 4) begin
                    if ((b & STREAM_FLAGS) == 8'h00) code = STATUS_NO_STREAM;
                end else begin
                    hdr_shift = {hdr_shift[23:0], b};
                end
                if (code != STATUS_DATA) begin
                    halted      = 1'b1;
                    emits       = 1'b1;
                    beat.status = code;
                end else begin
                    field_cnt = pos + 1;
                    if (pos >= 8) begin
                        data_ofs = hdr_shift;
                        if (data_ofs <= 9) begin
                            enter_prev();
                        end else begin
                            ph        = PH_OFS;
                            field_cnt = 9;
                        end
                    end
                end
            end
            PH_OFS: begin
                field_cnt = field_cnt + 1;
                if (field_cnt >= data_ofs) enter_prev();
            end
            PH_PREV: begin
                field_cnt = field_cnt + 1;
                if (field_cnt >= 4) begin
                    ph        = PH_TAG;
                    field_cnt = 0;
                    hdr_shift = 0;
                    stamp_ms  = 0;
                end
            end
            PH_TAG: begin
                pos = field_cnt;
                if (pos == 0) begin
                    tag_code = b;
                end else if (pos <= 3) begin
                    hdr_shift = {8'h00, hdr_shift[15:0], b};
                end else if (pos <= 6) begin
                    stamp_ms = {8'h00, stamp_ms[15:0], b};
                end else if (pos == 7) begin
                    stamp_ms[31:24] = b;
                end
                field_cnt = pos + 1;
                if (pos >= 10) begin
                    bytes_to_go = hdr_shift[23:0];
                    first_tag   = 1'b0;
                    if (bytes_to_go == 0) begin
                        enter_prev();
                    end else if (tag_code == TAG_AUDIO || tag_code == TAG_VIDEO) begin
                        ph = PH_CODEC;
                    end else begin
                        ph = PH_SKIP;
                    end
                end
            end
            PH_CODEC: begin
                codec_id    = b;
                bytes_to_go = bytes_to_go - 1;
                extra       = 0;
                if (tag_code == TAG_VIDEO) begin
                    if (!have_video) begin
                        have_video = 1'b1;
                        first_tag  = 1'b1;
                    end
                    if (b[3:0] == VCODEC_VP6) extra = 1;
                    else if (b[3:0] == VCODEC_VP6A) extra = 4;
                end else begin
                    if (!have_audio) begin
                        have_audio = 1'b1;
                        first_tag  = 1'b1;
                    end
                end
                if (extra > bytes_to_go) extra = bytes_to_go;
                if (extra != 0) begin
                    ph        = PH_EXTRA;
                    field_cnt = extra;
                end else begin
                    enter_payload();
                end
            end
            PH_EXTRA: begin
                bytes_to_go = bytes_to_go - 1;
                field_cnt   = field_cnt - 1;
                if (field_cnt == 0 || bytes_to_go == 0) enter_payload();
            end
            PH_SKIP: begin
                bytes_to_go = bytes_to_go - 1;
                if (bytes_to_go == 0) enter_prev();
            end
            PH_PAYLOAD: begin
                video       = (tag_code == TAG_VIDEO);
                hi          = codec_id[7:4];
                lo          = codec_id[3:0];
                bytes_to_go = bytes_to_go - 1;
                chunk_fill  = chunk_fill + 1;
                beat.frame_last = (bytes_to_go == 0);
                beat.chunk_last = beat.frame_last ||
                                  chunk_fill >= ((chunk_limit == 0) ? 17'd1 : chunk_limit);
                if (beat.chunk_last) chunk_fill = 0;
                if (video) begin
                    if (lo == VCODEC_H263) beat.codec = CODEC_H263;
                    else if (lo == VCODEC_VP6 || lo == VCODEC_VP6A) beat.codec = CODEC_VP6;
                    else beat.codec = CODEC_VIDEO_OTHER;
                end else begin
                    beat.codec = (hi <= 3) ? hi[2:0] : CODEC_AUDIO_OTHER;
                end
                beat.payload_byte = b;
                beat.is_video     = video;
                beat.keyframe     = video && hi == 4'd1;
                beat.pts_90k      = 39'(stamp_ms) * 39'd90;
                beat.status       = STATUS_DATA;
                beat.stream_first = first_tag;
                if (!video && first_tag) begin
                    beat.sample_rate = 16'd44100 >> (2'd3 - codec_id[3:2]);
                    beat.sample_bits = codec_id[1] ? 5'd16 : 5'd8;
                    beat.channels    = {1'b0, codec_id[0]} + 2'd1;
                end
                emits = 1'b1;
                if (beat.frame_last) enter_prev();
            end
            default: begin
                ph        = PH_HDR;
                field_cnt = 0;
            end
        endcase
    endfunction

    function automatic string beat_text(input flvd_result_t v);
        return $sformatf({"byte=%02h vid=%0d codec=%0d key=%0d pts=%0d cl=%0d fl=%0d ",
                          "st=%0d first=%0d rate=%0d bits=%0d ch=%0d"},
                         v.payload_byte, v.is_video, v.codec, v.keyframe, v.pts_90k,
                         v.chunk_last, v.frame_last, v.status, v.stream_first,
                         v.sample_rate, v.sample_bits, v.channels);
    endfunction

    function automatic void note_failure(input string what);
        fail_count = fail_count + 1;
        if (fail_count <= 10) $display("ERROR: %s", what);
    endfunction

    always @(posedge aclk) begin : scoreboard
        flvd_result_t beat;
        flvd_result_t seen;
        logic         emits;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                deframe_byte(s_data_byte, s_restart, emits, beat);
                if (plan_known) begin
                    emits       = plan_want_beat;
                    beat        = '0;
                    beat.status = plan_status;
                end
                if (emits) pending_beats.push_back(beat);
            end
            if (m_valid && m_ready) begin
                seen = {m_payload_byte, m_is_video, m_codec, m_keyframe, m_pts_90k,
                        m_chunk_last, m_frame_last, m_status, m_stream_first,
                        m_sample_rate, m_sample_bits, m_channels};
                result_count = result_count + 1;
                if (m_chunk_last === 1'b1) chunk_end_count = chunk_end_count + 1;
                if (m_frame_last === 1'b1) frame_end_count = frame_end_count + 1;
                if (m_status !== STATUS_DATA) error_beat_count = error_beat_count + 1;
                if (pending_beats.size() == 0) begin
                    note_failure($sformatf("result beat %0d with nothing outstanding: %s",
                                           result_count, beat_text(seen)));
                end else begin
                    beat = pending_beats.pop_front();
                    if (seen !== beat) begin
                        note_failure($sformatf("result beat %0d expected %s got %s",
                                               result_count, beat_text(beat),
                                               beat_text(seen)));
                    end
                end
            end
        end
    end

    // result side: draw a stall per beat, hold ready until the beat leaves
    initial begin : result_sink
        int stall;
        forever begin
            stall = sink_steady ? 0 : $urandom_range(0, 11);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic rs, input logic known,
                             input logic want_beat, input logic [1:0] status);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data_byte    <= b;
        s_restart      <= rs;
        plan_known     <= known;
        plan_want_beat <= want_beat;
        plan_status    <= status;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic reg_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= MAX_CHUNK_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_and_hold();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_random_file(input int budget);
        logic [7:0]  img[$];
        logic [7:0]  flags;
        logic [7:0]  kind;
        logic [7:0]  cbyte;
        logic [31:0] ofs;
        logic [31:0] stamp;
        logic [23:0] size;
        int          pick;
        int          bad_pos;
        int          keep;
        int          n_tags;
        int          i;
        int          t;
        file_count = file_count + 1;
        for (i = 0; i < 3; i++) img.push_back(FLV_SIG[23 - 8 * i -: 8]);
        img.push_back(FLV_VERSION);
        flags = 8'($urandom);
        if ((flags & STREAM_FLAGS) == 8'h00) begin
            flags = flags | (($urandom_range(0, 1) != 0) ? 8'h01 : 8'h04);
        end
        img.push_back(flags);
        pick = $urandom_range(0, 9);
        if (pick < 6) ofs = 9;
        else if (pick < 8) ofs = $urandom_range(0, 9);
        else ofs = $urandom_range(10, 40);
        for (i = 3; i >= 0; i--) img.push_back(ofs[8 * i +: 8]);

        // broken header: send up to the failing byte, then a little ignored tail
        if ($urandom_range(0, 15) == 0) begin
            bad_pos = $urandom_range(0, 4);
            if (bad_pos < 4) img[bad_pos] = img[bad_pos] ^ 8'($urandom_range(1, 255));
            else img[4] = 8'($urandom) & ~STREAM_FLAGS;
            for (i = 0; i <= bad_pos; i++) push_byte(img[i], i == 0, 1'b0, 1'b0, STATUS_DATA);
            pick = $urandom_range(0, 3);
            for (i = 0; i < pick; i++) push_byte(8'($urandom), 1'b0, 1'b0, 1'b0, STATUS_DATA);
            fed_beats = fed_beats + bad_pos + 1 + pick;
            return;
        end

        for (i = 9; i < ofs; i++) img.push_back(8'($urandom));
        n_tags = $urandom_range(1, 5);
        for (t = 0; t < n_tags; t++) begin
            for (i = 0; i < 4; i++) img.push_back(8'($urandom));
            pick = $urandom_range(0, 9);
            if (pick < 4) kind = TAG_AUDIO;
            else if (pick < 8) kind = TAG_VIDEO;
            else if (pick == 8) kind = TAG_SCRIPT;
            else kind = 8'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0) size = '0;
            else if (pick < 5) size = 24'($urandom_range(1, 5));
            else if (pick == 5) size = 24'($urandom_range(100, 400));
            else size = 24'($urandom_range(1, 24));
            pick = $urandom_range(0, 9);
            if (pick == 8) stamp = 32'h0;
            else if (pick == 9) stamp = 32'hFFFF_FFFF;
            else stamp = $urandom;
            img.push_back(kind);
            for (i = 2; i >= 0; i--) img.push_back(size[8 * i +: 8]);
            for (i = 2; i >= 0; i--) img.push_back(stamp[8 * i +: 8]);
            img.push_back(stamp[31:24]);
            for (i = 0; i < 3; i++) img.push_back(8'($urandom));
            if (size != 0) begin
                cbyte = 8'($urandom);
                if (kind == TAG_VIDEO) begin
                    if ($urandom_range(0, 1) != 0) cbyte[7:4] = 4'd1;
                    pick = $urandom_range(0, 3);
                    if (pick == 0) cbyte[3:0] = VCODEC_H263;
                    else if (pick == 1) cbyte[3:0] = VCODEC_VP6;
                    else if (pick == 2) cbyte[3:0] = VCODEC_VP6A;
                end
                img.push_back(cbyte);
                for (i = 1; i < size; i++) img.push_back(8'($urandom));
            end
        end

        // cut the file short now and then; the next file restarts mid-stream
        keep = img.size();
        if ($urandom_range(0, 9) == 0) keep = $urandom_range(9, img.size() - 1);
        if (keep > budget) keep = budget;
        for (i = 0; i < keep; i++) push_byte(img[i], i == 0, 1'b0, 1'b0, STATUS_DATA);
        fed_beats = fed_beats + keep;
    endtask

    initial begin : stimulus
        logic [31:0] rd;
        logic [31:0] wdata;
        int          phase;
        int          target;
        int          burst;
        int          r;
        clear_parse();
        chunk_limit = MAX_CHUNK_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain_and_hold();
                wdata = (phase == PHASES - 1) ? $urandom_range(1, 16) : limit_plan[phase];
                reg_access(1'b1, wdata, rd);
                chunk_limit = wdata[16:0];
            end
            reg_access(1'b0, 32'h0, rd);
            if (rd[16:0] !== chunk_limit) begin
                note_failure($sformatf("max_chunk_bytes reads %0h, expected %0h",
                                       rd[16:0], chunk_limit));
            end
            if (phase == 0) begin
                for (r = 0; r < $size(directed_rows); r++) begin
                    push_byte(directed_rows[r].data, directed_rows[r].restart,
                              directed_rows[r].known, directed_rows[r].want_beat,
                              directed_rows[r].status);
                end
                fed_beats = fed_beats + $size(directed_rows);
            end
            target = fed_beats + BEATS_PER_PHASE;
            while (fed_beats < target) begin
                src_steady  = ($urandom_range(0, 3) == 0);
                sink_steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 24) == 0) begin
                    noise_count = noise_count + 1;
                    burst = $urandom_range(1, 6);
                    for (r = 0; r < burst; r++) begin
                        push_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, 1'b0,
                                  STATUS_DATA);
                    end
                    fed_beats = fed_beats + burst;
                end else begin
                    send_random_file(target - fed_beats);
                end
            end
        end
        drain_and_hold();
        repeat (8) @(posedge aclk);
        $display("fed %0d input beats: %0d files, %0d noise bursts, %0d chunk limits",
                 fed_beats, file_count, noise_count, PHASES);
        $display("checked %0d result beats: %0d chunk ends, %0d frame ends, %0d header errors",
                 result_count, chunk_end_count, frame_end_count, error_beat_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures", fail_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
